@@ rtl/core/rqfl_pkg.sv @@
package rqfl_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = 5;

  typedef enum logic [2:0] {
    CMD_PUT_TAIL    = 3'd0,
    CMD_PUT_HEAD    = 3'd1,
    CMD_GET         = 3'd2,
    CMD_PEEK        = 3'd3,
    CMD_FLUSH       = 3'd4,
    CMD_CLEAR_STATS = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] data_out;
    logic [4:0]  count;
    logic        is_full;
    logic        not_empty;
    logic [4:0]  low_water;
    logic [31:0] put_count;
    logic [31:0] get_count;
    logic [31:0] peek_count;
    logic [31:0] empty_count;
    logic [31:0] full_count;
  } out_item_t;

endpackage

@@ rtl/core/ring_queue_fifo_lifo_watermark.sv @@
// Circular queue of up to 16 words of 32 bits, driven by one command per item:
// put at tail, put at head, get, peek, flush, clear statistics. Every accepted
// item produces exactly one result item carrying the status, the head word
// (for get and peek), the occupancy after the command, the low watermark of
// free slots and five wrapping event counters. An item is handled combinationally
// against the queue state and its result lands in the output register
// the next cycle; the block accepts one item per clock as long as the output
// register is empty or being drained. Writing the capacity register (0 reads
// as 1, values above 16 as 16) empties the queue and zeroes the statistics;
// stored words are kept but become unreachable.
module ring_queue_fifo_lifo_watermark (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rqfl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rqfl_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);
  import rqfl_pkg::*;

  logic [DataWidth-1:0] slot_r [Depth];

  logic [CntW-1:0] cap_r, cap_nxt;
  logic [IdxW-1:0] tail_r, tail_nxt;
  logic [IdxW-1:0] head_r, head_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] minf_r, minf_nxt;
  logic [31:0]     put_r, put_nxt;
  logic [31:0]     get_r, get_nxt;
  logic [31:0]     peek_r, peek_nxt;
  logic [31:0]     empty_r, empty_nxt;
  logic [31:0]     full_r, full_nxt;
  logic            out_valid_r;
  out_item_t       out_item_r, out_item_nxt;

  logic            accept;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] tail_inc, head_inc, head_dec;
  logic [CntW-1:0] free_slots;
  logic [CntW-1:0] cfg_cap;
  status_t         status;
  logic [31:0]     dout;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_cap = CntW'(1);
    end else if (cfg_data > CntW'(Depth)) begin
      cfg_cap = CntW'(Depth);
    end else begin
      cfg_cap = cfg_data;
    end
  end

  assign tail_inc = (({1'b0, tail_r} + 1'b1) >= (IdxW+1)'(cap_r)) ? '0 : tail_r + 1'b1;
  assign head_inc = (({1'b0, head_r} + 1'b1) >= (IdxW+1)'(cap_r)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IdxW'(cap_r - 1'b1) : head_r - 1'b1;

  always_comb begin
    tail_nxt   = tail_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    put_nxt    = put_r;
    get_nxt    = get_r;
    peek_nxt   = peek_r;
    empty_nxt  = empty_r;
    full_nxt   = full_r;
    status     = STAT_OK;
    dout       = '0;
    wr_en      = 1'b0;
    wr_idx     = tail_r;
    case (in_item.command) inside
      CMD_PUT_TAIL, CMD_PUT_HEAD: begin
        if (cnt_r >= cap_r) begin
          status   = STAT_FULL;
          full_nxt = full_r + 1'b1;
        end else begin
          wr_en = 1'b1;
          if (in_item.command == CMD_PUT_TAIL) begin
            wr_idx   = tail_r;
            tail_nxt = tail_inc;
          end else begin
            wr_idx   = head_dec;
            head_nxt = head_dec;
          end
          cnt_nxt = cnt_r + 1'b1;
          put_nxt = put_r + 1'b1;
        end
      end
      CMD_GET, CMD_PEEK: begin
        if (cnt_r == '0) begin
          status    = STAT_EMPTY;
          empty_nxt = empty_r + 1'b1;
        end else begin
          dout = 32'(slot_r[head_r]);
          if (in_item.command == CMD_GET) begin
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - 1'b1;
            get_nxt  = get_r + 1'b1;
          end else begin
            peek_nxt = peek_r + 1'b1;
          end
        end
      end
      CMD_FLUSH: begin
        cnt_nxt  = '0;
        tail_nxt = '0;
        head_nxt = '0;
      end
      CMD_CLEAR_STATS: begin
        put_nxt   = '0;
        get_nxt   = '0;
        peek_nxt  = '0;
        empty_nxt = '0;
        full_nxt  = '0;
      end
      default: begin
      end
    endcase

    free_slots = cap_r - cnt_nxt;
    minf_nxt   = (minf_r > free_slots) ? free_slots : minf_r;
    cap_nxt    = cap_r;

    out_item_nxt.status      = status;
    out_item_nxt.data_out    = dout;
    out_item_nxt.count       = cnt_nxt;
    out_item_nxt.is_full     = (cnt_nxt == cap_r);
    out_item_nxt.not_empty   = (cnt_nxt != '0);
    out_item_nxt.low_water   = minf_nxt;
    out_item_nxt.put_count   = put_nxt;
    out_item_nxt.get_count   = get_nxt;
    out_item_nxt.peek_count  = peek_nxt;
    out_item_nxt.empty_count = empty_nxt;
    out_item_nxt.full_count  = full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CntW'(Depth);
      tail_r  <= '0;
      head_r  <= '0;
      cnt_r   <= '0;
      minf_r  <= CntW'(Depth);
      put_r   <= '0;
      get_r   <= '0;
      peek_r  <= '0;
      empty_r <= '0;
      full_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cap_r   <= cfg_cap;
      tail_r  <= '0;
      head_r  <= '0;
      cnt_r   <= '0;
      minf_r  <= cfg_cap;
      put_r   <= '0;
      get_r   <= '0;
      peek_r  <= '0;
      empty_r <= '0;
      full_r  <= '0;
    end else if (accept) begin
      cap_r   <= cap_nxt;
      tail_r  <= tail_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      minf_r  <= minf_nxt;
      put_r   <= put_nxt;
      get_r   <= get_nxt;
      peek_r  <= peek_nxt;
      empty_r <= empty_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en && !cfg_valid) begin
      slot_r[wr_idx] <= in_item.data_in[DataWidth-1:0];
    end
  end

endmodule
